>>> src/sss_pkg.sv
// ----------------------------------------------------------------------------
// sss_pkg
// Shared types and constants for the sample set statistics block.
// ----------------------------------------------------------------------------
package sss_pkg;

  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 24;

  // Fixed port widths
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 11;
  localparam int MEAN_W   = 32;
  localparam int MEDIAN_W = 25;
  localparam int STD_W    = 32;

  localparam int MEAN_FRAC = 8;   // fraction bits of the mean
  localparam int VAR_FRAC  = 16;  // fraction bits of the variance (root halves it)
  localparam int ROOT_IN_W = 64;  // width fed to the square root unit

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SELECT,
    ST_MEAN,
    ST_MUL_SQ,
    ST_MUL_SS,
    ST_MUL_NN,
    ST_VAR_DIV,
    ST_ROOT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

endpackage

>>> src/sample_set_statistics.sv
// ----------------------------------------------------------------------------
// sample_set_statistics
// Min, max, mean, median and standard deviation over a marked sample set.
// ----------------------------------------------------------------------------
// Throughput: one sample per cycle while a set loads; one set in flight.
// After the marked sample, a radix select median scan runs over the sample
//   memory read port, then the mean divide, three shift-add multiplies, the
//   variance divide and the square root, one unit at a time.
// Reset: synchronous active low; clears counters and running stats. The
//   sample memory is not cleared, only entries of the current set are read.
// ----------------------------------------------------------------------------
module sample_set_statistics #(
  parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sss_pkg::SAMPLE_W-1:0]  in_sample,
  input  logic                          in_last_sample,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [sss_pkg::SAMPLE_W-1:0]  out_minimum,
  output logic [sss_pkg::SAMPLE_W-1:0]  out_maximum,
  output logic [sss_pkg::MEAN_W-1:0]    out_mean_value,
  output logic [sss_pkg::MEDIAN_W-1:0]  out_median_value,
  output logic [sss_pkg::STD_W-1:0]     out_std_deviation,
  output logic [sss_pkg::COUNT_W-1:0]   out_sample_count,
  output logic                          out_overflowed
);

  localparam int SB    = SAMPLE_BITS;
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int SUMW  = SB + CW;              // running sum
  localparam int SQW   = 2 * SB + CW;          // running sum of squares
  localparam int MA    = SQW;                  // multiplier operand widths
  localparam int MB    = SUMW;
  localparam int PW    = MA + MB;
  localparam int VNW   = PW + sss_pkg::VAR_FRAC;
  localparam int NUMW  = (VNW > sss_pkg::ROOT_IN_W) ? VNW : sss_pkg::ROOT_IN_W;
  localparam int DENW  = 2 * CW;
  localparam int RTW   = sss_pkg::ROOT_IN_W / 2;

  sss_pkg::state_t state_r, state_nxt;
  logic            go_r, go_nxt;

  // running set state
  logic [CW-1:0]   cnt_r;
  logic [SB-1:0]   min_r, max_r;
  logic [SUMW-1:0] sum_r;
  logic [SQW-1:0]  sq_r;
  logic            ovf_r;

  // intermediate results
  logic [SB:0]     med_r;
  logic [sss_pkg::MEAN_W-1:0] mean_r;
  logic [PW-1:0]   prod_r, diff_r;
  logic [DENW-1:0] nn_r;
  logic [sss_pkg::ROOT_IN_W-1:0] vq_r;

  // output register
  logic                         out_valid_r;
  logic [sss_pkg::SAMPLE_W-1:0] out_min_r, out_max_r;
  logic [sss_pkg::MEAN_W-1:0]   out_mean_r;
  logic [sss_pkg::MEDIAN_W-1:0] out_med_r;
  logic [sss_pkg::STD_W-1:0]    out_std_r;
  logic [sss_pkg::COUNT_W-1:0]  out_cnt_r;
  logic                         out_ovf_r;

  logic          in_fire, keep;
  logic [SB-1:0] s;
  logic [2*SB-1:0] s_sq;

  logic sel_start, mul_start, div_start, sqrt_start;
  sss_pkg::unit_sts_t sel_sts, mul_sts, div_sts, sqrt_sts, cur_sts;
  logic [SB-1:0]   val_a, val_b;
  logic [MA-1:0]   mul_a;
  logic [MB-1:0]   mul_b;
  logic [PW-1:0]   mul_p;
  logic [NUMW-1:0] div_num, div_quo;
  logic [DENW-1:0] div_den;
  logic [RTW-1:0]  root;
  logic [CW-1:0]   rank_a, rank_b;

  assign in_ready = (state_r == sss_pkg::ST_LOAD);
  assign in_fire  = in_valid && in_ready;
  assign keep     = cnt_r < CW'(MAX_SAMPLES);
  assign s        = in_sample[SB-1:0];
  assign s_sq     = s * s;
  assign rank_a   = (cnt_r - 1'b1) >> 1;
  assign rank_b   = cnt_r >> 1;

  // sample memory plus median select
  sss_store #(
    .MAX_SAMPLES(MAX_SAMPLES), .SAMPLE_BITS(SB), .CW(CW), .AW(AW)
  ) u_store (
    .clk(clk), .rst_n(rst_n),
    .wr_en(in_fire && keep), .wr_addr(cnt_r[AW-1:0]), .wr_data(s),
    .start(sel_start), .n(cnt_r), .rank_a(rank_a), .rank_b(rank_b),
    .sts(sel_sts), .val_a(val_a), .val_b(val_b)
  );

  // shared multiplier: n*sumsq, sum*sum, n*n
  always_comb begin
    case (state_r)
      sss_pkg::ST_MUL_SS: begin
        mul_a = {{(MA-SUMW){1'b0}}, sum_r};
        mul_b = sum_r;
      end
      sss_pkg::ST_MUL_NN: begin
        mul_a = {{(MA-CW){1'b0}}, cnt_r};
        mul_b = {{(MB-CW){1'b0}}, cnt_r};
      end
      default: begin
        mul_a = sq_r;
        mul_b = {{(MB-CW){1'b0}}, cnt_r};
      end
    endcase
  end

  sss_mul #(.AW_(MA), .BW_(MB)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start),
    .a(mul_a), .b(mul_b), .sts(mul_sts), .p(mul_p)
  );

  // shared divider: mean and variance
  always_comb begin
    if (state_r == sss_pkg::ST_VAR_DIV) begin
      div_num = {{(NUMW-VNW){1'b0}}, diff_r, {sss_pkg::VAR_FRAC{1'b0}}};
      div_den = nn_r;
    end else begin
      div_num = {{(NUMW-SUMW-sss_pkg::MEAN_FRAC){1'b0}}, sum_r,
                 {sss_pkg::MEAN_FRAC{1'b0}}};
      div_den = {{(DENW-CW){1'b0}}, cnt_r};
    end
  end

  sss_div #(.NW(NUMW), .DW(DENW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start),
    .num(div_num), .den(div_den), .sts(div_sts), .quo(div_quo)
  );

  sss_sqrt #(.VW(sss_pkg::ROOT_IN_W)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sqrt_start),
    .v(vq_r), .sts(sqrt_sts), .root(root)
  );

  // sequencer: launch one unit per state, advance on its done pulse
  always_comb begin
    state_nxt  = state_r;
    go_nxt     = go_r;
    sel_start  = 1'b0;
    mul_start  = 1'b0;
    div_start  = 1'b0;
    sqrt_start = 1'b0;
    case (state_r)
      sss_pkg::ST_SELECT: cur_sts = sel_sts;
      sss_pkg::ST_MEAN, sss_pkg::ST_VAR_DIV: cur_sts = div_sts;
      sss_pkg::ST_ROOT: cur_sts = sqrt_sts;
      sss_pkg::ST_MUL_SQ, sss_pkg::ST_MUL_SS, sss_pkg::ST_MUL_NN: cur_sts = mul_sts;
      default: cur_sts = '0;
    endcase
    case (state_r)
      sss_pkg::ST_LOAD: begin
        if (in_fire && in_last_sample) begin
          state_nxt = sss_pkg::ST_SELECT;
        end
      end
      sss_pkg::ST_EMIT: begin
        if (!out_valid_r) begin
          state_nxt = sss_pkg::ST_LOAD;
        end
      end
      default: begin
        if (!go_r) begin
          go_nxt = 1'b1;
          case (state_r)
            sss_pkg::ST_SELECT:                    sel_start  = 1'b1;
            sss_pkg::ST_MEAN, sss_pkg::ST_VAR_DIV: div_start  = 1'b1;
            sss_pkg::ST_ROOT:                      sqrt_start = 1'b1;
            default:                               mul_start  = 1'b1;
          endcase
        end else if (cur_sts.done) begin
          go_nxt = 1'b0;
          case (state_r)
            sss_pkg::ST_SELECT:  state_nxt = sss_pkg::ST_MEAN;
            sss_pkg::ST_MEAN:    state_nxt = sss_pkg::ST_MUL_SQ;
            sss_pkg::ST_MUL_SQ:  state_nxt = sss_pkg::ST_MUL_SS;
            sss_pkg::ST_MUL_SS:  state_nxt = sss_pkg::ST_MUL_NN;
            sss_pkg::ST_MUL_NN:  state_nxt = sss_pkg::ST_VAR_DIV;
            sss_pkg::ST_VAR_DIV: state_nxt = sss_pkg::ST_ROOT;
            default:             state_nxt = sss_pkg::ST_EMIT;
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sss_pkg::ST_LOAD;
      go_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      go_r    <= go_nxt;
    end
  end

  // running stats and set bookkeeping
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      min_r <= '1;
      max_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end else if (in_fire) begin
      if (keep) begin
        cnt_r <= cnt_r + 1'b1;
        if (s < min_r) min_r <= s;
        if (s > max_r) max_r <= s;
        sum_r <= sum_r + {{CW{1'b0}}, s};
        sq_r  <= sq_r + {{CW{1'b0}}, s_sq};
      end else begin
        // drop the sample, remember that the set lost data
        ovf_r <= 1'b1;
      end
    end else if (state_r == sss_pkg::ST_EMIT && !out_valid_r) begin
      cnt_r <= '0;
      min_r <= '1;
      max_r <= '0;
      sum_r <= '0;
      sq_r  <= '0;
      ovf_r <= 1'b0;
    end
  end

  // capture unit results as each one finishes
  always_ff @(posedge clk) begin
    if (go_r && cur_sts.done) begin
      case (state_r)
        sss_pkg::ST_SELECT:  med_r  <= {1'b0, val_a} + {1'b0, val_b};
        sss_pkg::ST_MEAN:    mean_r <= div_quo[sss_pkg::MEAN_W-1:0];
        sss_pkg::ST_MUL_SQ:  prod_r <= mul_p;
        // clamp a negative variance to zero
        sss_pkg::ST_MUL_SS:  diff_r <= (prod_r < mul_p) ? '0 : prod_r - mul_p;
        sss_pkg::ST_MUL_NN:  nn_r   <= mul_p[DENW-1:0];
        sss_pkg::ST_VAR_DIV: vq_r   <= div_quo[sss_pkg::ROOT_IN_W-1:0];
        default: ;
      endcase
    end
  end

  // output register: load once the previous transaction has been taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == sss_pkg::ST_EMIT && !out_valid_r) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == sss_pkg::ST_EMIT && !out_valid_r) begin
      out_min_r  <= sss_pkg::SAMPLE_W'(min_r);
      out_max_r  <= sss_pkg::SAMPLE_W'(max_r);
      out_mean_r <= mean_r;
      out_med_r  <= sss_pkg::MEDIAN_W'(med_r);
      out_std_r  <= root;
      out_cnt_r  <= sss_pkg::COUNT_W'(32'(cnt_r));
      out_ovf_r  <= ovf_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_minimum       = out_min_r;
  assign out_maximum       = out_max_r;
  assign out_mean_value    = out_mean_r;
  assign out_median_value  = out_med_r;
  assign out_std_deviation = out_std_r;
  assign out_sample_count  = out_cnt_r;
  assign out_overflowed    = out_ovf_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_SAMPLES))
    else $error("sample count exceeded capacity");
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> (cnt_r == CW'(MAX_SAMPLES)))
    else $error("overflow flagged while store not full");
  a_unit_running: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> (cur_sts.busy || cur_sts.done))
    else $error("sequencer waiting on an idle unit");
  a_emit_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == sss_pkg::ST_EMIT))
    else $error("result raised outside the emit state");

endmodule

>>> src/sss_store.sv
// ----------------------------------------------------------------------------
// sss_store
// Sample memory with a radix select engine that finds two ranked samples.
// ----------------------------------------------------------------------------
module sss_store #(
  parameter int MAX_SAMPLES = sss_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = sss_pkg::SAMPLE_BITS_DEF,
  parameter int CW          = $clog2(MAX_SAMPLES + 1),
  parameter int AW          = $clog2(MAX_SAMPLES)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  logic [SAMPLE_BITS-1:0] wr_data,
  input  logic                   start,
  input  logic [CW-1:0]          n,
  input  logic [CW-1:0]          rank_a,
  input  logic [CW-1:0]          rank_b,
  output sss_pkg::unit_sts_t     sts,
  output logic [SAMPLE_BITS-1:0] val_a,
  output logic [SAMPLE_BITS-1:0] val_b
);

  localparam int SB = SAMPLE_BITS;
  localparam int BW = $clog2(SB);

  logic [SB-1:0] mem [MAX_SAMPLES];
  logic [SB-1:0] rd_data_r;
  logic          rd_vld_r, rd_last_r;
  logic          active_r, done_r;
  logic [BW-1:0] bit_r;
  logic [CW-1:0] addr_r, n_r;
  logic [CW-1:0] k_a_r, k_b_r, c_a_r, c_b_r;
  logic [SB-1:0] pre_a_r, pre_b_r;

  logic          issue, hit_a, hit_b, resolve;
  logic [SB-1:0] mask, bit_sel;
  logic [CW-1:0] tot_a, tot_b;

  assign issue   = active_r && (addr_r < n_r);
  assign mask    = ({SB{1'b1}} << bit_r) << 1;
  assign bit_sel = {{(SB-1){1'b0}}, 1'b1} << bit_r;
  assign hit_a   = rd_vld_r && (((rd_data_r ^ pre_a_r) & mask) == '0) && !rd_data_r[bit_r];
  assign hit_b   = rd_vld_r && (((rd_data_r ^ pre_b_r) & mask) == '0) && !rd_data_r[bit_r];
  assign tot_a   = c_a_r + {{(CW-1){1'b0}}, hit_a};
  assign tot_b   = c_b_r + {{(CW-1){1'b0}}, hit_b};
  assign resolve = rd_vld_r && rd_last_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[addr_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      done_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
    end else begin
      done_r    <= 1'b0;
      rd_vld_r  <= issue;
      rd_last_r <= issue && (addr_r == n_r - 1'b1);
      if (start) begin
        active_r <= 1'b1;
        n_r      <= n;
        k_a_r    <= rank_a;
        k_b_r    <= rank_b;
        pre_a_r  <= '0;
        pre_b_r  <= '0;
        c_a_r    <= '0;
        c_b_r    <= '0;
        addr_r   <= '0;
        bit_r    <= BW'(SB - 1);
      end else if (resolve) begin
        // decide one bit of each ranked value, then rescan for the next bit
        if (k_a_r >= tot_a) begin
          pre_a_r <= pre_a_r | bit_sel;
          k_a_r   <= k_a_r - tot_a;
        end
        if (k_b_r >= tot_b) begin
          pre_b_r <= pre_b_r | bit_sel;
          k_b_r   <= k_b_r - tot_b;
        end
        c_a_r  <= '0;
        c_b_r  <= '0;
        addr_r <= '0;
        if (bit_r == '0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end else begin
          bit_r <= bit_r - 1'b1;
        end
      end else begin
        if (rd_vld_r) begin
          c_a_r <= tot_a;
          c_b_r <= tot_b;
        end
        if (issue) begin
          addr_r <= addr_r + 1'b1;
        end
      end
    end
  end

  assign sts.busy = active_r;
  assign sts.done = done_r;
  assign val_a    = pre_a_r;
  assign val_b    = pre_b_r;

  a_vld_active: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> active_r)
    else $error("read data returned outside a select pass");
  a_addr_bound: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (addr_r <= n_r))
    else $error("scan address ran past the sample count");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !active_r)
    else $error("select finished while still active");

endmodule

>>> src/sss_mul.sv
// ----------------------------------------------------------------------------
// sss_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module sss_mul #(
  parameter int AW_ = 59,
  parameter int BW_ = 35
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [AW_-1:0]     a,
  input  logic [BW_-1:0]     b,
  output sss_pkg::unit_sts_t sts,
  output logic [AW_+BW_-1:0] p
);

  localparam int PW = AW_ + BW_;
  localparam int NW = $clog2(BW_ + 1);

  logic          busy_r, done_r;
  logic [NW-1:0] cnt_r;
  logic [PW-1:0] a_r, p_r;
  logic [BW_-1:0] b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        a_r    <= {{BW_{1'b0}}, a};
        b_r    <= b;
        p_r    <= '0;
        cnt_r  <= NW'(BW_);
      end else if (busy_r) begin
        if (b_r[0]) begin
          p_r <= p_r + a_r;
        end
        a_r   <= a_r << 1;
        b_r   <= b_r >> 1;
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == NW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign p        = p_r;

endmodule

>>> src/sss_div.sv
// ----------------------------------------------------------------------------
// sss_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sss_div #(
  parameter int NW = 110,
  parameter int DW = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [NW-1:0]      num,
  input  logic [DW-1:0]      den,
  output sss_pkg::unit_sts_t sts,
  output logic [NW-1:0]      quo
);

  localparam int CNW = $clog2(NW + 1);

  logic           busy_r, done_r;
  logic [CNW-1:0] cnt_r;
  logic [NW-1:0]  num_r;
  logic [DW-1:0]  rem_r, den_r;
  logic [DW:0]    rem_sh, diff;
  logic           ge;

  assign rem_sh = {rem_r, num_r[NW-1]};
  assign ge     = rem_sh >= {1'b0, den_r};
  assign diff   = rem_sh - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        num_r  <= num;
        den_r  <= den;
        rem_r  <= '0;
        cnt_r  <= CNW'(NW);
      end else if (busy_r) begin
        rem_r <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
        num_r <= {num_r[NW-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quo      = num_r;

endmodule

>>> src/sss_sqrt.sv
// ----------------------------------------------------------------------------
// sss_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module sss_sqrt #(
  parameter int VW = sss_pkg::ROOT_IN_W
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [VW-1:0]      v,
  output sss_pkg::unit_sts_t sts,
  output logic [VW/2-1:0]    root
);

  localparam int RW  = VW / 2;
  localparam int CNW = $clog2(RW + 1);

  logic           busy_r, done_r;
  logic [CNW-1:0] cnt_r;
  logic [VW-1:0]  v_r;
  logic [RW+1:0]  rem_r;
  logic [RW-1:0]  root_r;
  logic [RW+3:0]  rem_sh, trial, diff;
  logic           ge;

  assign rem_sh = {rem_r, v_r[VW-1:VW-2]};
  assign trial  = {2'b00, root_r, 2'b01};
  assign ge     = rem_sh >= trial;
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        v_r    <= v;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= CNW'(RW);
      end else if (busy_r) begin
        rem_r  <= ge ? diff[RW+1:0] : rem_sh[RW+1:0];
        root_r <= {root_r[RW-2:0], ge};
        v_r    <= v_r << 2;
        cnt_r  <= cnt_r - 1'b1;
        if (cnt_r == CNW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign root     = root_r;

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for sample_set_statistics. Sample sets are streamed in
// over the valid/ready input channel. A predictor keeps its own copy of the
// current set and works out min, max, mean, median, standard deviation, count
// and overflow when the marked sample arrives. Each result transaction is
// compared field by field with the oldest expected set summary.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_DEPTH = 1024;      // MAX_SAMPLES of the instance
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int DRAIN_WAIT  = 1000;      // cycles after the last result
  localparam int LONG_HOLD   = 4000;      // receiver hold-off, in cycles
  localparam int RANDOM_ITEMS = 750;

  typedef struct packed {
    logic [sss_pkg::SAMPLE_W-1:0] minimum;
    logic [sss_pkg::SAMPLE_W-1:0] maximum;
    logic [sss_pkg::MEAN_W-1:0]   mean_value;
    logic [sss_pkg::MEDIAN_W-1:0] median_value;
    logic [sss_pkg::STD_W-1:0]    std_deviation;
    logic [sss_pkg::COUNT_W-1:0]  sample_count;
    logic                         overflowed;
  } set_summary_t;

  typedef struct {
    logic [sss_pkg::SAMPLE_W-1:0] sample;
    logic                         last;
    logic                         typed;    // summary below is written out by hand
    set_summary_t                 summary;
  } stim_row_t;

  logic                          clk;
  logic                          rst_n;
  logic                          in_valid;
  logic                          in_ready;
  logic [sss_pkg::SAMPLE_W-1:0]  in_sample;
  logic                          in_last_sample;
  logic                          out_valid;
  logic                          out_ready;
  logic [sss_pkg::SAMPLE_W-1:0]  out_minimum;
  logic [sss_pkg::SAMPLE_W-1:0]  out_maximum;
  logic [sss_pkg::MEAN_W-1:0]    out_mean_value;
  logic [sss_pkg::MEDIAN_W-1:0]  out_median_value;
  logic [sss_pkg::STD_W-1:0]     out_std_deviation;
  logic [sss_pkg::COUNT_W-1:0]   out_sample_count;
  logic                          out_overflowed;

  // Predictor state: samples kept so far in the open set, plus drop flag
  logic [sss_pkg::SAMPLE_W-1:0]  open_set[$];
  logic                          set_dropped;
  set_summary_t                  pending_summaries[$];

  int unsigned          mismatch_count;
  int unsigned          cycle_count;
  int                   burst_left;
  logic                 long_hold_req;
  stim_row_t            stim_rows[$];

  sample_set_statistics u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_sample         (in_sample),
    .in_last_sample    (in_last_sample),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_minimum       (out_minimum),
    .out_maximum       (out_maximum),
    .out_mean_value    (out_mean_value),
    .out_median_value  (out_median_value),
    .out_std_deviation (out_std_deviation),
    .out_sample_count  (out_sample_count),
    .out_overflowed    (out_overflowed)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Floor of the square root of a 64-bit value, bit by bit from the top
  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] root;
    logic [63:0] cand;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      cand = root | (64'd1 << b);
      if (cand * cand <= v) root = cand;
    end
    return root[31:0];
  endfunction

  // Summarize the open set. Sums are exact in 128 bits; the variance
  // numerator n*sumsq - sum^2 is scaled by 2^16 before the divide by n^2 so
  // that the root comes out with 8 fraction bits.
  function automatic set_summary_t summarize_open_set();
    set_summary_t                 s;
    logic [sss_pkg::SAMPLE_W-1:0] sorted[$];
    logic [127:0]                 n;
    logic [127:0]                 total;
    logic [127:0]                 square_total;
    logic [127:0]                 spread;
    logic [127:0]                 scaled;
    logic [63:0]                  variance_q;
    int                           cnt;
    cnt          = open_set.size();
    n            = cnt;
    total        = '0;
    square_total = '0;
    s.minimum    = '1;
    s.maximum    = '0;
    foreach (open_set[i]) begin
      if (open_set[i] < s.minimum) s.minimum = open_set[i];
      if (open_set[i] > s.maximum) s.maximum = open_set[i];
      total        = total + open_set[i];
      square_total = square_total + 128'(open_set[i]) * 128'(open_set[i]);
    end
    s.mean_value = 32'((total << sss_pkg::MEAN_FRAC) / n);
    sorted = open_set;
    sorted.sort();
    if (cnt % 2 == 0)
      s.median_value = 25'(sorted[cnt/2 - 1]) + 25'(sorted[cnt/2]);
    else
      s.median_value = 25'(sorted[cnt/2]) << 1;
    if (n * square_total < total * total) begin
      s.std_deviation = '0;
    end else begin
      spread     = n * square_total - total * total;
      scaled     = (spread << sss_pkg::VAR_FRAC) / (n * n);
      variance_q = scaled[63:0];
      s.std_deviation = floor_sqrt(variance_q);
    end
    s.sample_count = sss_pkg::COUNT_W'(cnt);
    s.overflowed   = set_dropped;
    return s;
  endfunction

  // Fold one accepted transaction into the predictor; close the set on last
  task automatic absorb_sample(logic [sss_pkg::SAMPLE_W-1:0] sample, logic last,
                               logic typed, set_summary_t typed_summary);
    if (open_set.size() < STORE_DEPTH) open_set = {open_set, sample};
    else set_dropped = 1'b1;
    if (last) begin
      if (typed) pending_summaries = {pending_summaries, typed_summary};
      else pending_summaries = {pending_summaries, summarize_open_set()};
      open_set.delete();
      set_dropped = 1'b0;
    end
  endtask

  // Offer one sample; valid stays up from a previous transaction when there
  // was no gap, so only one assignment per edge is made here
  task automatic offer_sample(logic [sss_pkg::SAMPLE_W-1:0] sample, logic last,
                              logic typed = 1'b0, set_summary_t typed_summary = '0);
    @(negedge clk);
    in_valid       = 1'b1;
    in_sample      = sample;
    in_last_sample = last;
    do @(posedge clk); while (!in_ready);
    absorb_sample(sample, last, typed, typed_summary);
    // Burst pacing: drop valid for a random gap once the burst runs out
    burst_left--;
    if (burst_left <= 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(1, 12);
    end
  endtask

  // Hold off until every expected summary has come out
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_summaries.size() != 0) @(posedge clk);
  endtask

  function automatic logic [sss_pkg::SAMPLE_W-1:0] pick_sample(int flavor);
    case (flavor)
      0:       return sss_pkg::SAMPLE_W'($urandom);
      1:       return sss_pkg::SAMPLE_W'($urandom_range(0, 255));
      2:       return ($urandom_range(0, 1) == 1) ? '1 : '0;
      default: return sss_pkg::SAMPLE_W'($urandom_range(1000, 1100));
    endcase
  endfunction

  // Send a whole set of n samples, the last one marked
  task automatic send_set(int n, int flavor);
    logic [sss_pkg::SAMPLE_W-1:0] fixed_value;
    fixed_value = pick_sample(0);
    for (int i = 0; i < n; i++)
      offer_sample(flavor == 4 ? fixed_value : pick_sample(flavor), i == n - 1);
  endtask

  function automatic void add_row(logic [sss_pkg::SAMPLE_W-1:0] sample, logic last,
                                  logic typed = 1'b0, set_summary_t summary = '0);
    stim_row_t r;
    r.sample  = sample;
    r.last    = last;
    r.typed   = typed;
    r.summary = summary;
    stim_rows = {stim_rows, r};
  endfunction

  // Result checker: compare each result transaction with the oldest summary
  always @(posedge clk) begin
    set_summary_t want;
    set_summary_t got;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_minimum, out_maximum, out_mean_value, out_median_value,
              out_std_deviation, out_sample_count, out_overflowed};
      if (pending_summaries.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("ERROR: unexpected result transaction, got %p", got);
      end else begin
        want = pending_summaries.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: result mismatch");
            $display("  min    exp %0d got %0d", want.minimum, got.minimum);
            $display("  max    exp %0d got %0d", want.maximum, got.maximum);
            $display("  mean   exp %h got %h", want.mean_value, got.mean_value);
            $display("  median exp %h got %h", want.median_value, got.median_value);
            $display("  stddev exp %h got %h", want.std_deviation, got.std_deviation);
            $display("  count  exp %0d got %0d", want.sample_count, got.sample_count);
            $display("  ovf    exp %b got %b", want.overflowed, got.overflowed);
          end
        end
      end
    end
  end

  // Receiver: stall on a random ready mask, sometimes one that never
  // stalls; on request hold ready low for a long stretch
  initial begin
    logic [7:0] mask;
    int         hold_left;
    int         phase;
    out_ready = 1'b0;
    hold_left = 0;
    phase     = 0;
    mask      = 8'hFF;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left     = LONG_HOLD;
      end
      if (phase % 64 == 0)
        mask = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom);
      phase++;
      if (hold_left > 0) begin
        hold_left--;
        out_ready = 1'b0;
      end else begin
        out_ready = mask[phase % 8];
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    int sent;
    int n;
    in_valid       = 1'b0;
    in_sample      = '0;
    in_last_sample = 1'b0;
    rst_n          = 1'b0;
    long_hold_req  = 1'b0;
    set_dropped    = 1'b0;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 4;

    // Directed rows; hand-written summaries only where they are obvious
    add_row('0, 1'b1, 1'b1, '{24'd0, 24'd0, 32'd0, 25'd0, 32'd0, 11'd1, 1'b0});
    add_row('1, 1'b1, 1'b1,
            '{24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFF00, 25'h1FFFFFE, 32'd0, 11'd1, 1'b0});
    add_row('0, 1'b0);
    add_row('1, 1'b1, 1'b1,
            '{24'd0, 24'hFFFFFF, 32'h7FFFFF80, 25'hFFFFFF, 32'h7FFFFF80, 11'd2, 1'b0});
    add_row(24'd5, 1'b0);
    add_row(24'd5, 1'b0);
    add_row(24'd5, 1'b1);               // equal samples, zero spread
    add_row(24'd4, 1'b0);
    add_row(24'd1, 1'b0);
    add_row(24'd3, 1'b0);
    add_row(24'd2, 1'b1);               // even count, median of middle pair
    add_row(24'd9, 1'b0);
    add_row(24'd1, 1'b0);
    add_row(24'd5, 1'b1);               // odd count, unsorted arrival
    add_row(24'hAAAAAA, 1'b0);
    add_row(24'h555555, 1'b0);
    add_row(24'd7, 1'b1);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (stim_rows[i])
      offer_sample(stim_rows[i].sample, stim_rows[i].last,
                   stim_rows[i].typed, stim_rows[i].summary);
    drain_results();

    // Store exactly full, then full with the marked sample dropped
    send_set(STORE_DEPTH, 0);
    drain_results();
    send_set(STORE_DEPTH + 3, 1);
    drain_results();

    // Long receiver hold-off while small sets keep coming: input backs up
    long_hold_req = 1'b1;
    for (int k = 0; k < 6; k++) send_set($urandom_range(1, 4), 0);
    drain_results();

    // Random sets: mostly small, now and then larger, varied content
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80)
                                      : $urandom_range(1, 12);
      send_set(n, $urandom_range(0, 4));
      sent += n;
      if ($urandom_range(0, 15) == 0) drain_results();
    end

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0 && pending_summaries.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
